@@ design/segment_reassembly_engine_assert.svh @@
// assertion macros for the segment reassembly engine
`ifndef SEGMENT_REASSEMBLY_ENGINE_ASSERT_SVH
`define SEGMENT_REASSEMBLY_ENGINE_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define SRE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define SRE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sre_pkg.sv @@
// package of types and constants for the segment reassembly engine
package sre_pkg;

    localparam int MAX_SEGMENTS = 1024;
    localparam int HEADER_BYTES = 7;

    localparam int MAP_IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int COUNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int POS_W     = 17;
    localparam int ADDR_W    = 26;

    localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_SEG_HI  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_SEG_LO  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_TOT_HI  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_TOT_LO  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_SIZE_HI = POS_W'(5);
    localparam logic [POS_W-1:0] POS_SIZE_LO = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(HEADER_BYTES);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_addr;
        logic [7:0]        write_data;
        logic              header_seen;
        logic [15:0]       total_segments;
        logic [3:0]        format_code;
        logic              complete;
        logic              bad_segment;
    } t_out_word;

endpackage

@@ design/segment_reassembly_engine.sv @@
// top level of the segment reassembly engine: header parse, received map, write output
// One byte word is taken per clock and each gives exactly one result word, so the block
// sustains one byte per cycle into a registered two-entry output queue; input ready drops
// only when that queue is full or the bitmap is being cleared. The received-segment bitmap
// lives in a 1024 x 1 synchronous RAM with one write port, read continuously at the index
// of the segment number latched from header bytes 1-2, so the lookup is ready by header
// byte 6, where the bit is tested and set. After reset a clearing pass zeroes the bitmap,
// one entry per cycle, during which no byte is accepted; stream id writes are taken at
// any time. The segment base address (segment-1)*size is formed once per frame at header
// byte 6 by one 16x16 multiply, and each payload byte adds its offset to that base.
module segment_reassembly_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [3:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sre_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sre_pkg::t_out_word o_out_word
);

    // configured stream id
    logic [3:0] r_stream;

    // frame parse state
    logic [sre_pkg::POS_W-1:0]   r_pos,     n_pos;
    logic                        r_match,   n_match;
    logic                        r_acc,     n_acc;
    logic [15:0]                 r_cur,     n_cur;
    logic [15:0]                 r_size,    n_size;
    logic [15:0]                 r_total,   n_total;
    logic [3:0]                  r_format,  n_format;
    logic                        r_started, n_started;
    logic [sre_pkg::COUNT_W-1:0] r_count,   n_count;
    logic [sre_pkg::ADDR_W-1:0]  r_base,    n_base;

    // bitmap ram and its clearing pass
    logic                          mem_map [sre_pkg::MAX_SEGMENTS];
    logic                          r_map_q;
    logic                          r_clr_busy;
    logic [sre_pkg::MAP_IDX_W-1:0] r_clr_idx;
    logic [sre_pkg::MAP_IDX_W-1:0] map_idx;
    logic                          map_we;

    // output queue
    sre_pkg::t_out_word r_q0, r_q1;
    logic [1:0]         r_qcnt;
    sre_pkg::t_out_word res;

    logic                      in_acc, out_pop;
    logic [15:0]               seg_m1;
    logic [31:0]               base_prod;
    logic [sre_pkg::POS_W-1:0] pay_off;
    logic                      bad;

    assign o_in_ready  = !r_clr_busy && (r_qcnt != 2'd2);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_qcnt != 2'd0);
    assign out_pop     = o_out_valid && i_out_ready;
    assign o_out_word  = r_q0;

    // map index follows the latched segment number; out-of-range numbers are flagged
    // bad before the bit is used
    assign seg_m1    = r_cur - 16'd1;
    assign map_idx   = seg_m1[sre_pkg::MAP_IDX_W-1:0];

    always_comb begin
        n_pos     = r_pos;
        n_match   = r_match;
        n_acc     = r_acc;
        n_cur     = r_cur;
        n_size    = r_size;
        n_total   = r_total;
        n_format  = r_format;
        n_started = r_started;
        n_count   = r_count;
        n_base    = r_base;
        map_we    = 1'b0;
        bad       = 1'b0;
        base_prod = 32'd0;
        pay_off   = '0;
        res       = '0;

        if (in_acc) begin
            if (i_in_word.frame_start) begin
                n_pos = '0;
            end else if (r_pos == sre_pkg::POS_MAX) begin
                n_pos = sre_pkg::POS_MAX;
            end else begin
                n_pos = r_pos + sre_pkg::POS_W'(1);
            end
            pay_off = n_pos - sre_pkg::POS_PAYLOAD;

            if (n_pos == '0) begin
                // byte 0: stream id and format
                n_match = (i_in_word.data_byte[7:4] == r_stream);
                n_acc   = 1'b0;
                if (n_match && !r_started) begin
                    n_format = i_in_word.data_byte[3:0];
                end
            end else if (r_match) begin
                if (n_pos == sre_pkg::POS_SEG_HI) begin
                    n_cur = {i_in_word.data_byte, 8'd0};
                end else if (n_pos == sre_pkg::POS_SEG_LO) begin
                    n_cur = {r_cur[15:8], i_in_word.data_byte};
                end else if (n_pos == sre_pkg::POS_TOT_HI) begin
                    if (!r_started) n_total = {i_in_word.data_byte, 8'd0};
                end else if (n_pos == sre_pkg::POS_TOT_LO) begin
                    if (!r_started) n_total = {r_total[15:8], i_in_word.data_byte};
                end else if (n_pos == sre_pkg::POS_SIZE_HI) begin
                    if (!r_started) n_size = {i_in_word.data_byte, 8'd0};
                end else if (n_pos == sre_pkg::POS_SIZE_LO) begin
                    // last header byte: latch once, then test and set the map bit
                    if (!r_started) begin
                        n_size    = {r_size[15:8], i_in_word.data_byte};
                        n_started = 1'b1;
                        n_count   = '0;
                    end
                    base_prod = {16'd0, seg_m1} * {16'd0, n_size};
                    n_base    = base_prod[sre_pkg::ADDR_W-1:0];
                    if ((r_cur == 16'd0) || (r_cur > r_total) ||
                        (r_cur > 16'(sre_pkg::MAX_SEGMENTS))) begin
                        bad   = 1'b1;
                        n_acc = 1'b0;
                    end else if (r_map_q) begin
                        // duplicate segment
                        n_acc = 1'b0;
                    end else begin
                        map_we  = 1'b1;
                        n_count = n_count + sre_pkg::COUNT_W'(1);
                        n_acc   = 1'b1;
                    end
                end else if (r_acc) begin
                    if (pay_off < {1'b0, r_size}) begin
                        res.write_valid = 1'b1;
                        res.write_data  = i_in_word.data_byte;
                        res.write_addr  = r_base +
                            sre_pkg::ADDR_W'(pay_off);
                    end
                end
            end

            res.header_seen    = n_started;
            res.total_segments = n_started ? n_total : 16'd0;
            res.format_code    = n_started ? n_format : 4'd0;
            res.complete       = n_started &&
                                 ({{(16 - sre_pkg::COUNT_W){1'b0}}, n_count} == n_total);
            res.bad_segment    = bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream   <= 4'd1;
            r_pos      <= '0;
            r_match    <= 1'b0;
            r_acc      <= 1'b0;
            r_cur      <= '0;
            r_size     <= '0;
            r_total    <= '0;
            r_format   <= '0;
            r_started  <= 1'b0;
            r_count    <= '0;
            r_base     <= '0;
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            if (i_cfg_we) r_stream <= i_cfg_data;
            r_pos     <= n_pos;
            r_match   <= n_match;
            r_acc     <= n_acc;
            r_cur     <= n_cur;
            r_size    <= n_size;
            r_total   <= n_total;
            r_format  <= n_format;
            r_started <= n_started;
            r_count   <= n_count;
            r_base    <= n_base;
            // clearing sweep over the bitmap after reset
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + sre_pkg::MAP_IDX_W'(1);
                if (r_clr_idx == sre_pkg::MAP_IDX_W'(sre_pkg::MAX_SEGMENTS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // bitmap ram: one write port, registered read at the latched segment
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem_map[r_clr_idx] <= 1'b0;
        end else if (map_we) begin
            mem_map[map_idx] <= 1'b1;
        end
        r_map_q <= mem_map[map_idx];
    end

    // two-entry output queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= 2'd0;
        end else begin
            case ({in_acc, out_pop})
                2'b10:   r_qcnt <= r_qcnt + 2'd1;
                2'b01:   r_qcnt <= r_qcnt - 2'd1;
                default: r_qcnt <= r_qcnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({in_acc, out_pop})
            2'b10: begin
                if (r_qcnt == 2'd0) r_q0 <= res;
                else                r_q1 <= res;
            end
            2'b01: begin
                r_q0 <= r_q1;
            end
            2'b11: begin
                if (r_qcnt == 2'd1) begin
                    r_q0 <= res;
                end else begin
                    r_q0 <= r_q1;
                    r_q1 <= res;
                end
            end
            default: begin
                r_q0 <= r_q0;
            end
        endcase
    end

    `include "segment_reassembly_engine_assert.svh"

    `SRE_ASSERT_IMPL(a_no_accept_in_clear, r_clr_busy, !in_acc, "byte taken during map clear")
    `SRE_ASSERT_ALWAYS(a_count_bound, r_count <= sre_pkg::COUNT_W'(sre_pkg::MAX_SEGMENTS), "count overflow")
    `SRE_ASSERT_IMPL(a_write_after_header, o_out_valid && o_out_word.write_valid, o_out_word.header_seen, "early write")
    `SRE_ASSERT_NEXT(a_map_set_counts, map_we && !r_clr_busy, r_count == $past(n_count), "map set without count")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the segment reassembly engine
module testbench;

    localparam int RESET_CYCLES    = 6;
    localparam int ITEMS_PER_PHASE = 333;
    localparam int STALL_LIMIT     = 4096;   // well above the bitmap clear after reset
    localparam int TAIL_CYCLES     = 16;

    localparam logic [3:0] STREAM_MIN = 4'd1;
    localparam logic [3:0] STREAM_MAX = 4'd15;

    // the first matching header carries these; its total, size and format stay latched for the whole run
    localparam logic [15:0] FIRST_SEG    = 16'd20;
    localparam logic [15:0] FIRST_TOTAL  = 16'd20;
    localparam logic [15:0] FIRST_SIZE   = 16'd8;
    localparam logic [3:0]  FIRST_FORMAT = 4'd3;
    localparam logic [sre_pkg::ADDR_W-1:0] FIRST_BASE =
        sre_pkg::ADDR_W'((FIRST_SEG - 1) * FIRST_SIZE);

    // a word's result is either typed in here or left to the predictor
    typedef struct packed {
        bit                 typed;
        sre_pkg::t_out_word want;
    } t_hint;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        t_hint      hint;
    } t_dir_row;

    localparam t_hint BY_PREDICTOR = '{typed: 1'b0, want: '0};
    localparam t_hint NOTHING_YET  = '{typed: 1'b1, want: '0};
    localparam t_hint HEADER_LATCHED = '{typed: 1'b1, want: '{
        write_valid: 1'b0, write_addr: '0, write_data: 8'h00, header_seen: 1'b1,
        total_segments: FIRST_TOTAL, format_code: FIRST_FORMAT, complete: 1'b0,
        bad_segment: 1'b0}};
    localparam t_hint WROTE_LOW = '{typed: 1'b1, want: '{
        write_valid: 1'b1, write_addr: FIRST_BASE, write_data: 8'h00, header_seen: 1'b1,
        total_segments: FIRST_TOTAL, format_code: FIRST_FORMAT, complete: 1'b0,
        bad_segment: 1'b0}};
    localparam t_hint WROTE_HIGH = '{typed: 1'b1, want: '{
        write_valid: 1'b1, write_addr: FIRST_BASE + 1'b1, write_data: 8'hFF,
        header_seen: 1'b1, total_segments: FIRST_TOTAL, format_code: FIRST_FORMAT,
        complete: 1'b0, bad_segment: 1'b0}};
    localparam t_hint FLAGGED_BAD = '{typed: 1'b1, want: '{
        write_valid: 1'b0, write_addr: '0, write_data: 8'h00, header_seen: 1'b1,
        total_segments: FIRST_TOTAL, format_code: FIRST_FORMAT, complete: 1'b0,
        bad_segment: 1'b1}};

    localparam int DIR_ROWS_N = 26;
    localparam t_dir_row DIR_ROWS [DIR_ROWS_N] = '{
        // stray byte before any frame start
        '{8'hFF, 1'b0, NOTHING_YET},
        // frame of another stream
        '{8'h2F, 1'b1, NOTHING_YET},
        '{8'h00, 1'b0, NOTHING_YET},
        // first frame of our stream: last segment, latches total, size, format
        '{{STREAM_MIN, FIRST_FORMAT}, 1'b1, NOTHING_YET},
        '{FIRST_SEG[15:8],   1'b0, NOTHING_YET},
        '{FIRST_SEG[7:0],    1'b0, NOTHING_YET},
        '{FIRST_TOTAL[15:8], 1'b0, NOTHING_YET},
        '{FIRST_TOTAL[7:0],  1'b0, NOTHING_YET},
        '{FIRST_SIZE[15:8],  1'b0, NOTHING_YET},
        '{FIRST_SIZE[7:0],   1'b0, HEADER_LATCHED},
        '{8'h00, 1'b0, WROTE_LOW},
        '{8'hFF, 1'b0, WROTE_HIGH},
        // frame cut short by a new start: segment 65535, past the bitmap
        '{8'h1F, 1'b1, BY_PREDICTOR},
        '{8'hFF, 1'b0, BY_PREDICTOR},
        '{8'hFF, 1'b0, BY_PREDICTOR},
        '{8'hFF, 1'b0, BY_PREDICTOR},
        '{8'hFF, 1'b0, BY_PREDICTOR},
        '{8'hFF, 1'b0, BY_PREDICTOR},
        '{8'hFF, 1'b0, FLAGGED_BAD},
        // segment number zero
        '{8'h10, 1'b1, BY_PREDICTOR},
        '{8'h00, 1'b0, BY_PREDICTOR},
        '{8'h00, 1'b0, BY_PREDICTOR},
        '{8'h00, 1'b0, BY_PREDICTOR},
        '{8'h00, 1'b0, BY_PREDICTOR},
        '{8'h00, 1'b0, BY_PREDICTOR},
        '{8'h00, 1'b0, FLAGGED_BAD}
    };

    logic               clk;
    logic               rst_n    = 1'b0;
    logic               cfg_we   = 1'b0;
    logic [3:0]         cfg_data = 4'd0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    sre_pkg::t_in_word  in_word  = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    sre_pkg::t_out_word out_word;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // predictor state
    logic [3:0]                stream_sel    = STREAM_MIN;
    logic [sre_pkg::POS_W-1:0] pr_pos        = '0;
    bit                        pr_match      = 1'b0;
    bit                        pr_take       = 1'b0;
    logic [15:0]               pr_seg        = '0;
    logic [15:0]               pr_size       = '0;
    logic [15:0]               pr_total      = '0;
    logic [3:0]                pr_format     = '0;
    bit                        pr_latched    = 1'b0;
    bit                        pr_seen_map [sre_pkg::MAX_SEGMENTS];
    int unsigned               pr_seen_count = 0;

    t_hint              word_hints[$];
    sre_pkg::t_out_word expected_words[$];

    int unsigned mismatch_count = 0;
    int unsigned words_in       = 0;
    int unsigned results_seen   = 0;
    int unsigned writes_seen    = 0;
    int unsigned bad_seen       = 0;
    bit          complete_seen  = 1'b0;

    segment_reassembly_engine u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one byte word in, one status/write word out
    function automatic sre_pkg::t_out_word reassemble_byte(input sre_pkg::t_in_word w);
        sre_pkg::t_out_word r;
        int unsigned        offset;
        r = '0;
        if (w.frame_start) begin
            pr_pos = '0;
        end else if (pr_pos != sre_pkg::POS_MAX) begin
            pr_pos = pr_pos + 1'b1;
        end
        offset = 32'(pr_pos) - sre_pkg::HEADER_BYTES;
        if (pr_pos == '0) begin
            pr_match = (w.data_byte[7:4] == stream_sel);
            pr_take  = 1'b0;
            if (pr_match && !pr_latched) pr_format = w.data_byte[3:0];
        end else if (pr_match) begin
            case (pr_pos)
                sre_pkg::POS_SEG_HI: pr_seg = {w.data_byte, 8'h00};
                sre_pkg::POS_SEG_LO: pr_seg = pr_seg | 16'(w.data_byte);
                sre_pkg::POS_TOT_HI: if (!pr_latched) pr_total = {w.data_byte, 8'h00};
                sre_pkg::POS_TOT_LO: if (!pr_latched) pr_total[7:0] = w.data_byte;
                sre_pkg::POS_SIZE_HI: if (!pr_latched) pr_size = {w.data_byte, 8'h00};
                sre_pkg::POS_SIZE_LO: begin
                    // first matching header: latch and start a fresh bitmap
                    if (!pr_latched) begin
                        pr_size[7:0]  = w.data_byte;
                        pr_latched    = 1'b1;
                        pr_seen_map   = '{default: 1'b0};
                        pr_seen_count = 0;
                    end
                    if (pr_seg == 0 || pr_seg > pr_total ||
                        pr_seg > sre_pkg::MAX_SEGMENTS) begin
                        r.bad_segment = 1'b1;
                        pr_take       = 1'b0;
                    end else if (pr_seen_map[pr_seg - 1]) begin
                        pr_take = 1'b0;   // duplicate, payload dropped
                    end else begin
                        pr_seen_map[pr_seg - 1] = 1'b1;
                        pr_seen_count++;
                        pr_take = 1'b1;
                    end
                end
                default: if (pr_take && offset < 32'(pr_size)) begin
                    r.write_valid = 1'b1;
                    r.write_data  = w.data_byte;
                    r.write_addr  = sre_pkg::ADDR_W'((32'(pr_seg) - 1) * 32'(pr_size)
                                                     + offset);
                end
            endcase
        end
        r.header_seen = pr_latched;
        if (pr_latched) begin
            r.total_segments = pr_total;
            r.format_code    = pr_format;
            r.complete       = (pr_seen_count == 32'(pr_total));
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // receiver stalls at random
    always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // both handshakes, sampled at the edge
    always @(posedge clk) begin : monitor
        sre_pkg::t_out_word predicted;
        sre_pkg::t_out_word want;
        t_hint              hint;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                predicted = reassemble_byte(in_word);
                hint = word_hints.pop_front();
                expected_words.push_back(hint.typed ? hint.want : predicted);
                words_in++;
            end
            if (out_valid && out_ready) begin
                results_seen++;
                if (out_word.write_valid) writes_seen++;
                if (out_word.bad_segment) bad_seen++;
                if (out_word.complete) complete_seen = 1'b1;
                if (expected_words.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("write_valid", 32'(want.write_valid),
                                32'(out_word.write_valid));
                    check_field("write_addr", 32'(want.write_addr),
                                32'(out_word.write_addr));
                    check_field("write_data", 32'(want.write_data),
                                32'(out_word.write_data));
                    check_field("header_seen", 32'(want.header_seen),
                                32'(out_word.header_seen));
                    check_field("total_segments", 32'(want.total_segments),
                                32'(out_word.total_segments));
                    check_field("format_code", 32'(want.format_code),
                                32'(out_word.format_code));
                    check_field("complete", 32'(want.complete), 32'(out_word.complete));
                    check_field("bad_segment", 32'(want.bad_segment),
                                32'(out_word.bad_segment));
                end
            end
        end
    end

    // ends the run if no word moves on either side for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: %0d cycles with no word moving", quiet);
        $display("testbench: errors");
        $finish;
    end

    // one byte word; valid stays up from one word to the next unless the sender idles
    task automatic send_word(input logic [7:0] data_byte, input logic frame_start,
                             input t_hint hint);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        word_hints.push_back(hint);
        in_word  <= '{data_byte: data_byte, frame_start: frame_start};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // hold off the sender until every result has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
    endtask

    task automatic write_stream_id(input logic [3:0] id);
        cfg_data <= id;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we     <= 1'b0;
        stream_sel = id;
    endtask

    // mostly well-formed frames of our stream, plus other streams and loose bytes
    task automatic send_random_frame(inout int unsigned counted);
        int unsigned pick;
        int unsigned n;
        int unsigned hdr_len;
        int unsigned pay_len;
        logic [15:0] seg;
        logic [3:0]  other;
        logic [7:0]  hdr [sre_pkg::HEADER_BYTES];
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            // another stream: ignored whatever follows
            do other = 4'($urandom_range(0, 15)); while (other == stream_sel);
            send_word({other, 4'($urandom_range(0, 15))}, 1'b1, BY_PREDICTOR);
            n = $urandom_range(0, 20);
            repeat (n) send_word(8'($urandom), 1'b0, BY_PREDICTOR);
        end else if (pick < 18) begin
            // loose bytes that extend whatever frame is open
            n = $urandom_range(1, 6);
            repeat (n) send_word(8'($urandom), 1'b0, BY_PREDICTOR);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // lean toward the lowest missing segment so completion is reached
                seg = 16'($urandom_range(1, pr_total));
                for (int s = 1; s <= pr_total && s <= sre_pkg::MAX_SEGMENTS; s++) begin
                    if (!pr_seen_map[s - 1]) begin
                        seg = 16'(s);
                        break;
                    end
                end
            end else if (pick < 75) begin
                seg = 16'($urandom_range(1, pr_total));
            end else if (pick < 83) begin
                seg = 16'd0;
            end else if (pick < 91) begin
                seg = 16'($urandom_range(pr_total + 1, sre_pkg::MAX_SEGMENTS));
            end else begin
                seg = 16'($urandom_range(sre_pkg::MAX_SEGMENTS + 1, 16'hFFFF));
            end
            // later headers carry random total, size and format, all ignored
            hdr[0] = {stream_sel, 4'($urandom_range(0, 15))};
            hdr[1] = seg[15:8];
            hdr[2] = seg[7:0];
            for (int i = 3; i < sre_pkg::HEADER_BYTES; i++) hdr[i] = 8'($urandom);
            hdr_len = ($urandom_range(0, 99) < 8)
                      ? $urandom_range(1, sre_pkg::HEADER_BYTES - 1)
                      : sre_pkg::HEADER_BYTES;
            for (int i = 0; i < hdr_len; i++) send_word(hdr[i], i == 0, BY_PREDICTOR);
            counted += hdr_len;
            if (hdr_len == sre_pkg::HEADER_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) pay_len = pr_size;
                else if (pick < 85) pay_len = $urandom_range(0, pr_size);
                else pay_len = pr_size + $urandom_range(1, 4);
                repeat (pay_len) send_word(8'($urandom), 1'b0, BY_PREDICTOR);
                counted += pay_len;
            end
        end
    endtask

    initial begin : stimulus
        int unsigned counted;
        bit          paused;
        logic [3:0]  phase_ids [3];
        phase_ids[0] = STREAM_MIN;
        phase_ids[1] = STREAM_MAX;
        phase_ids[2] = 4'($urandom_range(STREAM_MIN + 1, STREAM_MAX - 1));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            // receiver-heavy idling, then sender-heavy, then none
            case (phase)
                0:       begin send_idle_pct = 33; recv_idle_pct = 58; end
                1:       begin send_idle_pct = 58; recv_idle_pct = 33; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            write_stream_id(phase_ids[phase]);

            if (phase == 0) begin
                foreach (DIR_ROWS[i])
                    send_word(DIR_ROWS[i].data_byte, DIR_ROWS[i].frame_start,
                              DIR_ROWS[i].hint);
            end

            counted = 0;
            paused  = 1'b0;
            while (counted < ITEMS_PER_PHASE) begin
                send_random_frame(counted);
                if (phase == 1 && !paused && counted >= ITEMS_PER_PHASE / 2) begin
                    wait_for_results();
                    paused = 1'b1;
                end
            end

            wait_for_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d byte words in, %0d result words checked, 3 stream ids",
                 words_in, results_seen);
        $display("run: %0d payload writes, %0d bad segments, completion %s",
                 writes_seen, bad_seen, complete_seen ? "reached" : "not reached");
        if (mismatch_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

@@ segment_reassembly_engine.f @@
+incdir+design
design/sre_pkg.sv
design/segment_reassembly_engine.sv
sim/testbench.sv
